// File: rtl/core/rdf_pkg.sv
package rdf_pkg;

  localparam logic [7:0] SYNC_BYTE = 8'h55;
  localparam logic [7:0] CRC_POLY  = 8'h07;
  localparam logic [7:0] CRC_INIT  = 8'h00;

  // Byte positions inside a frame
  localparam logic [2:0] POS_SYNC  = 3'd0;
  localparam logic [2:0] POS_NODE  = 3'd1;
  localparam logic [2:0] POS_REG   = 3'd2;
  localparam logic [2:0] POS_VAL3  = 3'd3;
  localparam logic [2:0] POS_VAL2  = 3'd4;
  localparam logic [2:0] POS_VAL1  = 3'd5;
  localparam logic [2:0] POS_VAL0  = 3'd6;
  localparam logic [2:0] POS_WLAST = 3'd7;
  localparam logic [2:0] POS_RLAST = 3'd3;

  localparam logic KIND_READ  = 1'b0;
  localparam logic KIND_WRITE = 1'b1;

  typedef struct packed {
    logic        kind;
    logic [7:0]  node_address;
    logic [7:0]  register_address;
    logic [31:0] write_value;
  } rdf_req_t;

  typedef struct packed {
    logic [7:0] frame_byte;
    logic       last_byte;
  } rdf_res_t;

  // One CRC-8 byte update, message bits LSB first, register shifts MSB first
  function automatic logic [7:0] crc_feed(input logic [7:0] crc, input logic [7:0] data);
    logic [7:0] c;
    logic       fb;
    c = crc;
    for (int i = 0; i < 8; i++) begin
      fb = c[7] ^ data[i];
      c  = {c[6:0], 1'b0};
      if (fb) begin
        c = c ^ CRC_POLY;
      end
    end
    return c;
  endfunction

  // CRC after the constant sync byte
  localparam logic [7:0] CRC_SYNC = crc_feed(CRC_INIT, SYNC_BYTE);

endpackage

// File: rtl/core/register_datagram_framer.sv
// A request passes through CRC stages s1..s4 and the serializer register, then its bytes
// leave on out_result one a cycle. One request per frame is taken, set by the byte-serial
// output register; up to four further requests wait in the CRC pipeline meanwhile.
// out_strobe marks each byte for exactly one cycle; the receiver cannot stall.
// Reset (rst_n low, synchronous) clears all valid bits; no item is emitted after it.
module register_datagram_framer (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  rdf_pkg::rdf_req_t in_request,
  output logic              out_strobe,
  output rdf_pkg::rdf_res_t out_result
);
  import rdf_pkg::*;

  // CRC pipeline: s1 node, s2 register + value byte 3, s3 value bytes 2..1, s4 byte 0
  logic       s1_v_r, s2_v_r, s3_v_r, s4_v_r;
  rdf_req_t   s1_req_r, s2_req_r, s3_req_r, s4_req_r;
  logic [7:0] s1_crc_r;
  logic [7:0] s2_crc_rd_r, s2_crc_w_r;
  logic [7:0] s3_crc_rd_r, s3_crc_w_r;
  logic [7:0] s4_crc_r;

  // byte serializer
  logic       ser_v_r;
  rdf_req_t   ser_req_r;
  logic [7:0] ser_crc_r;
  logic [2:0] ser_idx_r;

  logic       ser_last;
  logic       ser_load;
  logic       adv1, adv2, adv3;
  logic       accept;
  logic [7:0] s2_crc_rd_nxt;
  logic [7:0] byte_sel;

  assign ser_last = ser_v_r && (ser_req_r.kind == KIND_WRITE ? ser_idx_r == POS_WLAST
                                                             : ser_idx_r == POS_RLAST);
  assign ser_load = s4_v_r && (!ser_v_r || ser_last);
  assign adv3     = s3_v_r && (!s4_v_r || ser_load);
  assign adv2     = s2_v_r && (!s3_v_r || adv3);
  assign adv1     = s1_v_r && (!s2_v_r || adv2);
  assign busy     = s1_v_r && !adv1;
  assign accept   = start && !busy;

  assign s2_crc_rd_nxt = crc_feed(s1_crc_r, s1_req_r.register_address);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
      s4_v_r <= 1'b0;
    end else begin
      if (accept) begin
        s1_v_r <= 1'b1;
      end else if (adv1) begin
        s1_v_r <= 1'b0;
      end
      if (adv1) begin
        s2_v_r <= 1'b1;
      end else if (adv2) begin
        s2_v_r <= 1'b0;
      end
      if (adv2) begin
        s3_v_r <= 1'b1;
      end else if (adv3) begin
        s3_v_r <= 1'b0;
      end
      if (adv3) begin
        s4_v_r <= 1'b1;
      end else if (ser_load) begin
        s4_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_req_r <= in_request;
      s1_crc_r <= crc_feed(CRC_SYNC, in_request.node_address);
    end
    if (adv1) begin
      s2_req_r    <= s1_req_r;
      s2_crc_rd_r <= s2_crc_rd_nxt;
      s2_crc_w_r  <= crc_feed(s2_crc_rd_nxt, s1_req_r.write_value[31:24]);
    end
    if (adv2) begin
      s3_req_r    <= s2_req_r;
      s3_crc_rd_r <= s2_crc_rd_r;
      s3_crc_w_r  <= crc_feed(crc_feed(s2_crc_w_r, s2_req_r.write_value[23:16]),
                              s2_req_r.write_value[15:8]);
    end
    if (adv3) begin
      s4_req_r <= s3_req_r;
      s4_crc_r <= (s3_req_r.kind == KIND_WRITE)
                  ? crc_feed(s3_crc_w_r, s3_req_r.write_value[7:0]) : s3_crc_rd_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ser_v_r   <= 1'b0;
      ser_idx_r <= POS_SYNC;
    end else if (ser_load) begin
      ser_v_r   <= 1'b1;
      ser_idx_r <= POS_SYNC;
    end else if (ser_v_r) begin
      if (ser_last) begin
        ser_v_r <= 1'b0;
      end else begin
        ser_idx_r <= ser_idx_r + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ser_load) begin
      ser_req_r <= s4_req_r;
      ser_crc_r <= s4_crc_r;
    end
  end

  always_comb begin
    case (ser_idx_r)
      POS_SYNC:  byte_sel = SYNC_BYTE;
      POS_NODE:  byte_sel = ser_req_r.node_address;
      POS_REG:   byte_sel = ser_req_r.register_address;
      POS_VAL3:  byte_sel = (ser_req_r.kind == KIND_WRITE) ? ser_req_r.write_value[31:24]
                                                          : ser_crc_r;
      POS_VAL2:  byte_sel = ser_req_r.write_value[23:16];
      POS_VAL1:  byte_sel = ser_req_r.write_value[15:8];
      POS_VAL0:  byte_sel = ser_req_r.write_value[7:0];
      POS_WLAST: byte_sel = ser_crc_r;
      default:   byte_sel = ser_crc_r;
    endcase
  end

  assign out_strobe            = ser_v_r;
  assign out_result.frame_byte = byte_sel;
  assign out_result.last_byte  = ser_last;

  // A frame starting after a gap opens with the sync byte
  a_sync_first: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && !$past(out_strobe) |-> out_result.frame_byte == SYNC_BYTE)
    else $error("frame did not open with sync byte");

  // After the last byte either the line goes quiet or a new frame starts with sync
  a_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && out_result.last_byte |=>
      !out_strobe || (out_result.frame_byte == SYNC_BYTE && ser_idx_r == POS_SYNC))
    else $error("frame not restarted cleanly after last byte");

  // Read frames never run past their CRC byte
  a_read_len: assert property (@(posedge clk) disable iff (!rst_n)
    ser_v_r && ser_req_r.kind == KIND_READ |-> ser_idx_r <= POS_RLAST)
    else $error("read frame too long");

  // Busy only when the entry stage holds an item that cannot move on
  a_busy_src: assert property (@(posedge clk) disable iff (!rst_n)
    busy |-> s1_v_r && s2_v_r && s3_v_r && s4_v_r)
    else $error("busy without a full pipeline");

endmodule

// File: verif/register_datagram_framer_test.sv
`timescale 1ns / 1ps

module register_datagram_framer_test;
  import rdf_pkg::*;

  localparam int STALL_LIMIT = 1000;
  localparam int DRAIN_CYCLES = 20;

  logic     clk;
  logic     rst_n;
  logic     start;
  logic     busy;
  rdf_req_t in_request;
  logic     out_strobe;
  rdf_res_t out_result;

  rdf_res_t expected_bytes[$];
  int       error_count = 0;
  int       stall_cycles = 0;
  bit       gaps_enabled;

  register_datagram_framer i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_request (in_request),
    .out_strobe (out_strobe),
    .out_result (out_result)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // CRC-8, poly 0x07, message bits LSB first into an MSB-first shift register
  function automatic logic [7:0] crc8_add_byte(input logic [7:0] crc, input logic [7:0] data);
    logic [7:0] r;
    r = crc;
    for (int b = 0; b < 8; b++) begin
      if (r[7] ^ data[b]) begin
        r = {r[6:0], 1'b0} ^ CRC_POLY;
      end else begin
        r = {r[6:0], 1'b0};
      end
    end
    return r;
  endfunction

  task automatic queue_datagram(input rdf_req_t req);
    logic [7:0] body[$];
    logic [7:0] crc;
    rdf_res_t   res;
    body = {SYNC_BYTE, req.node_address, req.register_address};
    if (req.kind == KIND_WRITE) begin
      body.push_back(req.write_value[31:24]);
      body.push_back(req.write_value[23:16]);
      body.push_back(req.write_value[15:8]);
      body.push_back(req.write_value[7:0]);
    end
    crc = 8'h00;
    foreach (body[i]) begin
      crc = crc8_add_byte(crc, body[i]);
      res.frame_byte = body[i];
      res.last_byte  = 1'b0;
      expected_bytes.push_back(res);
    end
    res.frame_byte = crc;
    res.last_byte  = 1'b1;
    expected_bytes.push_back(res);
  endtask

  function automatic rdf_req_t make_request(input logic kind, input logic [7:0] node,
                                            input logic [7:0] addr, input logic [31:0] value);
    rdf_req_t req;
    req.kind             = kind;
    req.node_address     = node;
    req.register_address = addr;
    req.write_value      = value;
    return req;
  endfunction

  function automatic rdf_req_t random_request();
    return make_request($urandom_range(0, 1) ? KIND_WRITE : KIND_READ,
                        8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), $urandom);
  endfunction

  // Drive at the falling edge, take acceptance at the rising edge
  task automatic send_request(input rdf_req_t req);
    int gap;
    gap = gaps_enabled ? $urandom_range(0, 12) : 0;
    repeat (gap) begin
      @(negedge clk);
      start <= 1'b0;
    end
    @(negedge clk);
    start      <= 1'b1;
    in_request <= req;
    do @(posedge clk); while (busy !== 1'b0);
    queue_datagram(req);
  endtask

  task automatic test_read_requests();
    gaps_enabled = 1'b1;
    send_request(make_request(KIND_READ, 8'h00, 8'h00, 32'h0000_0000));
    send_request(make_request(KIND_READ, 8'hFF, 8'hFF, 32'h0000_0000));
    send_request(make_request(KIND_READ, 8'h00, 8'hFF, 32'hFFFF_FFFF));
    send_request(make_request(KIND_READ, 8'hFF, 8'h00, 32'hDEAD_BEEF));
    send_request(make_request(KIND_READ, 8'h01, 8'h7F, 32'h0000_0000));
    send_request(make_request(KIND_READ, 8'h80, 8'h80, 32'h0000_0001));
  endtask

  task automatic test_write_requests();
    gaps_enabled = 1'b1;
    send_request(make_request(KIND_WRITE, 8'h00, 8'h80, 32'h0000_0000));
    send_request(make_request(KIND_WRITE, 8'hFF, 8'hFF, 32'hFFFF_FFFF));
    send_request(make_request(KIND_WRITE, 8'h00, 8'h00, 32'h8000_0001));
    send_request(make_request(KIND_WRITE, 8'h55, 8'hEC, 32'h0102_0304));
    send_request(make_request(KIND_WRITE, 8'hAA, 8'h6C, 32'hAAAA_5555));
    send_request(make_request(KIND_WRITE, 8'h01, 8'h7F, 32'h7FFF_FFFE));
    send_request(make_request(KIND_WRITE, 8'h80, 8'h81, 32'h00FF_FF00));
    send_request(make_request(KIND_WRITE, 8'hFE, 8'h01, 32'hFF00_00FF));
  endtask

  // Requests offered every cycle so they pile up behind the output register
  task automatic test_back_to_back();
    gaps_enabled = 1'b0;
    send_request(make_request(KIND_READ,  8'h11, 8'h22, 32'h0));
    send_request(make_request(KIND_WRITE, 8'h33, 8'hA4, 32'h1234_5678));
    send_request(make_request(KIND_READ,  8'h44, 8'h05, 32'hFFFF_FFFF));
    send_request(make_request(KIND_READ,  8'hFF, 8'hFF, 32'h0));
    send_request(make_request(KIND_WRITE, 8'h00, 8'h00, 32'h0));
    send_request(make_request(KIND_WRITE, 8'hC3, 8'hBC, 32'hCAFE_F00D));
    send_request(make_request(KIND_READ,  8'h3C, 8'h10, 32'h0));
    send_request(make_request(KIND_WRITE, 8'h99, 8'hF0, 32'h8765_4321));
  endtask

  task automatic test_random_traffic();
    for (int n = 0; n < 150; n++) begin
      // alternate stretches with and without sender gaps
      if (n % 25 == 0) begin
        gaps_enabled = (n / 25) % 2 == 0;
      end
      send_request(random_request());
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_strobe) begin
      if (expected_bytes.size() == 0) begin
        $error("unexpected byte %02h last %0b", out_result.frame_byte, out_result.last_byte);
        error_count++;
      end else begin
        rdf_res_t exp_res;
        exp_res = expected_bytes.pop_front();
        if (out_result.frame_byte !== exp_res.frame_byte) begin
          $error("frame_byte expected %02h actual %02h",
                 exp_res.frame_byte, out_result.frame_byte);
          error_count++;
        end
        if (out_result.last_byte !== exp_res.last_byte) begin
          $error("last_byte expected %0b actual %0b",
                 exp_res.last_byte, out_result.last_byte);
          error_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((start && !busy) || out_strobe) begin
        stall_cycles <= 0;
      end else if (stall_cycles + 1 >= STALL_LIMIT) begin
        $display("simulation failed");
        $finish;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
    end
  end

  initial begin
    rst_n        = 1'b0;
    start        = 1'b0;
    in_request   = '0;
    gaps_enabled = 1'b1;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_read_requests();
    test_write_requests();
    test_back_to_back();
    test_random_traffic();

    @(negedge clk);
    start <= 1'b0;
    while (expected_bytes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (error_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
